FILE: hw/rtl/rwf_pkg.sv
`default_nettype none

package rwf_pkg;

    localparam int unsigned MaxDetectionsDefault = 64;
    localparam int unsigned CoordW = 24;
    localparam int unsigned MarginW = 23;
    localparam int unsigned ScoreW = 16;
    localparam int unsigned HeadW = 3;
    localparam int unsigned IndexW = 6;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 24;
    localparam int unsigned WinW = CoordW + 2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FILTER_ENABLE   = 3'd0,
        CFG_TRANSFORM_OK    = 3'd1,
        CFG_AXIS_SWAP       = 3'd2,
        CFG_FRONT_BACK_LOW  = 3'd3,
        CFG_FRONT_BACK_HIGH = 3'd4,
        CFG_LEFT_RIGHT_LOW  = 3'd5,
        CFG_LEFT_RIGHT_HIGH = 3'd6,
        CFG_WINDOW_MARGIN   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ERR_OK           = 2'd0,
        ERR_TRANSFORM    = 2'd1,
        ERR_WINDOW_EMPTY = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        PICK_NONE    = 2'd0,
        PICK_ONE     = 2'd1,
        PICK_SEVERAL = 2'd2
    } t_pick;

    typedef struct packed {
        logic                      filter_en;
        logic                      transform_ok;
        logic                      axis_swap;
        logic signed [CoordW-1:0]  fb_low;
        logic signed [CoordW-1:0]  fb_high;
        logic signed [CoordW-1:0]  lr_low;
        logic signed [CoordW-1:0]  lr_high;
        logic        [MarginW-1:0] margin;
    } t_cfg;

    typedef struct packed {
        logic in_window;
        t_err err;
    } t_win;

endpackage

`default_nettype wire

FILE: hw/rtl/rwf_window.sv
`default_nettype none

module rwf_window (
    input  var rwf_pkg::t_cfg                     i_cfg,
    input  wire logic signed [rwf_pkg::CoordW-1:0] i_pos_x,
    input  wire logic signed [rwf_pkg::CoordW-1:0] i_pos_y,
    output var rwf_pkg::t_win                     o_win
);
    import rwf_pkg::*;

    logic signed [WinW-1:0] margin;
    logic signed [WinW-1:0] fb_lo;
    logic signed [WinW-1:0] fb_hi;
    logic signed [WinW-1:0] lr_lo;
    logic signed [WinW-1:0] lr_hi;
    logic signed [WinW-1:0] fb;
    logic signed [WinW-1:0] lr;

    assign margin = $signed({{(WinW-MarginW){1'b0}}, i_cfg.margin});
    assign fb_lo  = WinW'(i_cfg.fb_low) + margin;
    assign fb_hi  = WinW'(i_cfg.fb_high) - margin;
    assign lr_lo  = WinW'(i_cfg.lr_low) + margin;
    assign lr_hi  = WinW'(i_cfg.lr_high) - margin;
    assign fb     = i_cfg.axis_swap ? WinW'(i_pos_y) : WinW'(i_pos_x);
    assign lr     = i_cfg.axis_swap ? WinW'(i_pos_x) : WinW'(i_pos_y);

    always_comb begin
        o_win.in_window = (fb >= fb_lo) && (fb <= fb_hi) && (lr >= lr_lo) && (lr <= lr_hi);
        priority if (!i_cfg.transform_ok) begin
            o_win.err = ERR_TRANSFORM;
        end else if ((fb_lo > fb_hi) || (lr_lo > lr_hi)) begin
            o_win.err = ERR_WINDOW_EMPTY;
        end else begin
            o_win.err = ERR_OK;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/roi_window_filter_best_pick.sv
// A detection accepted into the input register moves on into the result register once
// that register is free, and its result is offered from there.
// Throughput: one detection per cycle; while a result waits, one more detection is taken
// into the input register, and then the input stalls until that result transfers.
// Reset (synchronous, active low) clears both stage valids, the frame counters,
// the running best pick and all configuration registers.
`default_nettype none

module roi_window_filter_best_pick #(
    parameter int unsigned MAX_DETECTIONS = rwf_pkg::MaxDetectionsDefault
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_cfg_we,
    input  wire logic [rwf_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  wire logic [rwf_pkg::CfgDataW-1:0]      i_cfg_data,

    input  wire logic                              i_valid,
    output var  logic                              o_ready,
    input  wire logic                              i_has_coords,
    input  wire logic signed [rwf_pkg::CoordW-1:0] i_pos_x,
    input  wire logic signed [rwf_pkg::CoordW-1:0] i_pos_y,
    input  wire logic                              i_grabbable,
    input  wire logic [rwf_pkg::ScoreW-1:0]        i_score,
    input  wire logic [rwf_pkg::HeadW-1:0]         i_head_kind,
    input  wire logic                              i_last_item,

    output var  logic                              o_valid,
    input  wire logic                              i_ready,
    output var  logic                              o_kept,
    output var  logic [rwf_pkg::IndexW-1:0]        o_kept_index,
    output var  logic                              o_frame_done,
    output var  logic [1:0]                        o_error_code,
    output var  logic                              o_selection_valid,
    output var  logic [1:0]                        o_pick_status,
    output var  logic                              o_has_primary,
    output var  logic [rwf_pkg::IndexW-1:0]        o_primary_index,
    output var  logic [rwf_pkg::HeadW-1:0]         o_primary_head_kind
);
    import rwf_pkg::*;

    localparam int unsigned CntW = $clog2(MAX_DETECTIONS + 1);

    t_cfg r_cfg;

    logic                     r_a_valid;
    logic                     r_a_has_coords;
    logic signed [CoordW-1:0] r_a_pos_x;
    logic signed [CoordW-1:0] r_a_pos_y;
    logic                     r_a_grabbable;
    logic [ScoreW-1:0]        r_a_score;
    logic [HeadW-1:0]         r_a_head;
    logic                     r_a_last;

    logic [CntW-1:0]   r_kept_count;
    t_pick             r_grab;
    logic              r_best_valid;
    logic [ScoreW-1:0] r_lead_score;
    logic [IndexW-1:0] r_best_index;
    logic [HeadW-1:0]  r_best_head;

    logic [CntW-1:0]   n_kept_count;
    t_pick             n_grab;
    logic              n_best_valid;
    logic [ScoreW-1:0] n_lead_score;
    logic [IndexW-1:0] n_best_index;
    logic [HeadW-1:0]  n_best_head;

    logic              r_o_valid;
    logic              r_o_kept;
    logic [IndexW-1:0] r_o_kept_index;
    logic              r_o_frame_done;
    t_err              r_o_err;
    logic              r_o_sel_valid;
    t_pick             r_o_pick;
    logic              r_o_has_primary;
    logic [IndexW-1:0] r_o_primary_index;
    logic [HeadW-1:0]  r_o_primary_head;

    logic              n_kept;
    t_err              n_err;
    logic              n_sel_valid;
    t_pick             n_pick;
    logic              n_has_primary;
    logic [IndexW-1:0] n_primary_index;
    logic [HeadW-1:0]  n_primary_head;

    t_win  win;
    logic  b_free;
    logic  a_move;
    logic  in_xfer;
    logic  room;
    logic  take_best;

    rwf_window u_window (
        .i_cfg   (r_cfg),
        .i_pos_x (r_a_pos_x),
        .i_pos_y (r_a_pos_y),
        .o_win   (win)
    );

    assign b_free  = !r_o_valid || i_ready;
    assign a_move  = r_a_valid && b_free;
    assign o_ready = !r_a_valid || b_free;
    assign in_xfer = i_valid && o_ready;
    assign room    = r_kept_count < CntW'(MAX_DETECTIONS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FILTER_ENABLE:   r_cfg.filter_en    <= i_cfg_data[0];
                CFG_TRANSFORM_OK:    r_cfg.transform_ok <= i_cfg_data[0];
                CFG_AXIS_SWAP:       r_cfg.axis_swap    <= i_cfg_data[0];
                CFG_FRONT_BACK_LOW:  r_cfg.fb_low       <= $signed(i_cfg_data[CoordW-1:0]);
                CFG_FRONT_BACK_HIGH: r_cfg.fb_high      <= $signed(i_cfg_data[CoordW-1:0]);
                CFG_LEFT_RIGHT_LOW:  r_cfg.lr_low       <= $signed(i_cfg_data[CoordW-1:0]);
                CFG_LEFT_RIGHT_HIGH: r_cfg.lr_high      <= $signed(i_cfg_data[CoordW-1:0]);
                CFG_WINDOW_MARGIN:   r_cfg.margin       <= i_cfg_data[MarginW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
        if (in_xfer) begin
            r_a_has_coords <= i_has_coords;
            r_a_pos_x      <= i_pos_x;
            r_a_pos_y      <= i_pos_y;
            r_a_grabbable  <= i_grabbable;
            r_a_score      <= i_score;
            r_a_head       <= i_head_kind;
            r_a_last       <= i_last_item;
        end
    end

    always_comb begin
        if (!r_cfg.filter_en) begin
            n_err  = ERR_OK;
            n_kept = room;
        end else begin
            n_err  = win.err;
            n_kept = (win.err == ERR_OK) && r_a_has_coords && win.in_window && room;
        end

        n_kept_count = r_kept_count;
        n_grab       = r_grab;
        n_best_valid = r_best_valid;
        n_lead_score = r_lead_score;
        n_best_index = r_best_index;
        n_best_head  = r_best_head;
        take_best    = !r_best_valid || (r_a_score > r_lead_score);

        if (n_kept) begin
            n_kept_count = r_kept_count + CntW'(1);
            if (r_cfg.filter_en && r_a_grabbable) begin
                n_grab = (r_grab == PICK_NONE) ? PICK_ONE : PICK_SEVERAL;
                if (take_best) begin
                    n_best_valid = 1'b1;
                    n_lead_score = r_a_score;
                    n_best_index = IndexW'(r_kept_count);
                    n_best_head  = r_a_head;
                end
            end
        end
    end

    always_comb begin
        n_sel_valid     = 1'b0;
        n_pick          = PICK_NONE;
        n_has_primary   = 1'b0;
        n_primary_index = '0;
        n_primary_head  = '0;
        if (r_a_last && r_cfg.filter_en) begin
            n_sel_valid = 1'b1;
            if ((n_err == ERR_OK) && (n_grab != PICK_NONE)) begin
                n_pick          = n_grab;
                n_has_primary   = n_best_valid;
                n_primary_index = n_best_valid ? n_best_index : '0;
                n_primary_head  = n_best_valid ? n_best_head : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_count <= '0;
            r_grab       <= PICK_NONE;
            r_best_valid <= 1'b0;
            r_lead_score <= '0;
            r_best_index <= '0;
            r_best_head  <= '0;
        end else if (a_move) begin
            if (r_a_last) begin
                r_kept_count <= '0;
                r_grab       <= PICK_NONE;
                r_best_valid <= 1'b0;
                r_lead_score <= '0;
                r_best_index <= '0;
                r_best_head  <= '0;
            end else begin
                r_kept_count <= n_kept_count;
                r_grab       <= n_grab;
                r_best_valid <= n_best_valid;
                r_lead_score <= n_lead_score;
                r_best_index <= n_best_index;
                r_best_head  <= n_best_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_free) begin
            r_o_valid <= r_a_valid;
        end
        if (a_move) begin
            r_o_kept          <= n_kept;
            r_o_kept_index    <= n_kept ? IndexW'(r_kept_count) : '0;
            r_o_frame_done    <= r_a_last;
            r_o_err           <= n_err;
            r_o_sel_valid     <= n_sel_valid;
            r_o_pick          <= n_pick;
            r_o_has_primary   <= n_has_primary;
            r_o_primary_index <= n_primary_index;
            r_o_primary_head  <= n_primary_head;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_kept              = r_o_kept;
    assign o_kept_index        = r_o_kept_index;
    assign o_frame_done        = r_o_frame_done;
    assign o_error_code        = r_o_err;
    assign o_selection_valid   = r_o_sel_valid;
    assign o_pick_status       = r_o_pick;
    assign o_has_primary       = r_o_has_primary;
    assign o_primary_index     = r_o_primary_index;
    assign o_primary_head_kind = r_o_primary_head;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_count <= CntW'(MAX_DETECTIONS))
        else $error("kept count exceeds capacity");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_move && r_a_last |=> r_kept_count == '0 && !r_best_valid && r_grab == PICK_NONE)
        else $error("frame state not cleared after last item");

    a_kept_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_kept |-> r_o_err == ERR_OK)
        else $error("detection kept while an error is reported");

    a_primary_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_has_primary |-> r_o_frame_done && r_o_sel_valid
            && r_o_pick != PICK_NONE)
        else $error("primary reported outside a valid frame summary");

    a_err_no_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err != ERR_OK |-> !r_o_kept && r_o_pick == PICK_NONE)
        else $error("error result carries a kept item or a pick");

endmodule

`default_nettype wire
